[rtl/core/dtyp_pkg.sv]
package dtyp_pkg;

    // Datapath widths. Components are normalized so the larger magnitude sits
    // near 2^31; CORDIC growth and the gain-scaled vertical term need 38 bits.
    localparam int CORDIC_W = 38;
    localparam int BAM_W    = 32;
    localparam int SHIFT_W  = 5;
    localparam int MAG_W    = 32;
    localparam int NEGZ_W   = 33;
    localparam int GAIN_W   = 31;
    localparam int ANGLE_W  = 25;
    localparam int DEG_W    = 41;
    localparam int MAX_STAGES = 32;

    // CORDIC gain in Q30, applied to the vertical term before the pitch pass.
    localparam logic [GAIN_W-1:0] GAIN_Q30 = 31'd1768195363;

    localparam logic [BAM_W-1:0] HALF_TURN = 32'h8000_0000;

    localparam logic [8:0] DEG_90  = 9'd90;
    localparam logic [8:0] DEG_180 = 9'd180;
    localparam logic [8:0] DEG_270 = 9'd270;
    localparam logic [8:0] DEG_360 = 9'd360;

    // atan(2^-i) in binary angle units, one turn = 2^32.
    localparam logic [BAM_W-1:0] STEP_ANGLE [MAX_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic [CORDIC_W-1:0] a;
        logic [CORDIC_W-1:0] b;
        logic [BAM_W-1:0]    ang;
    } cordic_vec_t;

    // Carried alongside the yaw pass.
    typedef struct packed {
        logic [CORDIC_W-1:0] vert;
        logic [SHIFT_W-1:0]  kd;
        logic                zero;
        logic                zpos;
    } yaw_side_t;

    // Carried alongside the pitch pass.
    typedef struct packed {
        logic [BAM_W-1:0] yaw_ang;
        logic             zero;
        logic             zpos;
    } pitch_side_t;

endpackage

[rtl/core/dtyp_dir_if.sv]
interface dtyp_dir_if #(
    parameter int COMPONENT_BITS = 24
);
    logic                      valid;
    logic                      ready;
    logic [COMPONENT_BITS-1:0] dir_x;
    logic [COMPONENT_BITS-1:0] dir_y;
    logic [COMPONENT_BITS-1:0] dir_z;

    modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
    modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

[rtl/core/dtyp_angle_if.sv]
interface dtyp_angle_if;
    logic                         valid;
    logic                         ready;
    logic [dtyp_pkg::ANGLE_W-1:0] yaw_angle;
    logic [dtyp_pkg::ANGLE_W-1:0] pitch_angle;

    modport source (output valid, output yaw_angle, output pitch_angle, input ready);
    modport sink   (input valid, input yaw_angle, input pitch_angle, output ready);
endinterface

[rtl/core/dtyp_cordic_stage.sv]
// One registered CORDIC vectoring iteration; sideband rides along unchanged.
module dtyp_cordic_stage #(
    parameter int SHIFT  = 0,
    parameter int SIDE_W = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  dtyp_pkg::cordic_vec_t in_vec,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output dtyp_pkg::cordic_vec_t out_vec,
    output logic [SIDE_W-1:0]     out_side
);

    logic signed [dtyp_pkg::CORDIC_W-1:0] a;
    logic signed [dtyp_pkg::CORDIC_W-1:0] b;
    logic signed [dtyp_pkg::CORDIC_W-1:0] da;
    logic signed [dtyp_pkg::CORDIC_W-1:0] db;
    logic                                 b_pos;
    dtyp_pkg::cordic_vec_t                vec_next;
    dtyp_pkg::cordic_vec_t                vec_reg;
    logic [SIDE_W-1:0]                    side_reg;
    logic                                 valid_reg;

    always_comb
    begin
        a     = in_vec.a;
        b     = in_vec.b;
        da    = b >>> SHIFT;
        db    = a >>> SHIFT;
        b_pos = !b[dtyp_pkg::CORDIC_W-1] && (b != '0);
        if (b_pos)
        begin
            vec_next.a   = a + da;
            vec_next.b   = b - db;
            vec_next.ang = in_vec.ang + dtyp_pkg::STEP_ANGLE[SHIFT];
        end
        else
        begin
            vec_next.a   = a - da;
            vec_next.b   = b + db;
            vec_next.ang = in_vec.ang - dtyp_pkg::STEP_ANGLE[SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg  <= vec_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

endmodule

[rtl/core/direction_to_yaw_pitch.sv]
// Registers from input accept to output valid: S1 to S5, the yaw CORDIC pass, SH,
// the pitch CORDIC pass, SD1 and the output register.
// Throughput: one item per cycle; the whole pipeline stalls only while the
// output skid register is occupied.
// Reset: rst_n clears every valid bit asynchronously; datapath registers are
// not reset.
module direction_to_yaw_pitch #(
    parameter int COMPONENT_BITS  = 24,
    parameter int ANGLE_FRAC_BITS = 16,
    parameter int CORDIC_STAGES   = 20
) (
    input  logic         clk,
    input  logic         rst_n,
    dtyp_dir_if.sink     dir,
    dtyp_angle_if.source angles
);

    localparam int CW = dtyp_pkg::CORDIC_W;
    localparam int NS = (CORDIC_STAGES > dtyp_pkg::MAX_STAGES) ? dtyp_pkg::MAX_STAGES
                                                              : CORDIC_STAGES;
    localparam int YAW_SIDE_W   = $bits(dtyp_pkg::yaw_side_t);
    localparam int PITCH_SIDE_W = $bits(dtyp_pkg::pitch_side_t);
    localparam int DW = dtyp_pkg::DEG_W;
    localparam int AW = dtyp_pkg::ANGLE_W;

    // Degree conversion: deg = (bam*360 + 2^(31-F)) >> (32-F), wrapped at 360.
    localparam logic [DW-1:0] DEG_RND   = DW'(1) << (31 - ANGLE_FRAC_BITS);
    localparam int            DEG_SHR   = 32 - ANGLE_FRAC_BITS;
    localparam logic [DW-1:0] FULL_TURN = DW'(dtyp_pkg::DEG_360) << ANGLE_FRAC_BITS;
    localparam logic [DW-1:0] PITCH_UP  = DW'(dtyp_pkg::DEG_270) << ANGLE_FRAC_BITS;
    localparam logic [DW-1:0] PITCH_DN  = DW'(dtyp_pkg::DEG_90) << ANGLE_FRAC_BITS;

    // Left shift that brings a nonzero magnitude into [2^30, 2^31).
    function automatic logic [dtyp_pkg::SHIFT_W-1:0] norm_shift(
        input logic [dtyp_pkg::MAG_W-1:0] m
    );
        logic [dtyp_pkg::SHIFT_W-1:0] msb;
        logic [dtyp_pkg::SHIFT_W-1:0] sh;
        msb = '0;
        for (int i = 0; i < dtyp_pkg::MAG_W; i++)
        begin
            if (m[i])
            begin
                msb = dtyp_pkg::SHIFT_W'(i);
            end
        end
        if (msb >= 5'd30)
        begin
            sh = '0;
        end
        else
        begin
            sh = 5'd30 - msb;
        end
        return sh;
    endfunction

    // Whole pipeline advances unless the skid register holds an item.
    logic adv;
    logic skid_valid_reg;
    logic skid_valid_next;

    assign adv       = !skid_valid_reg;
    assign dir.ready = adv;

    // ------------------------------------------------------------------
    // S1: input capture
    // ------------------------------------------------------------------
    logic                      s1_valid_reg;
    logic [COMPONENT_BITS-1:0] s1_x_reg;
    logic [COMPONENT_BITS-1:0] s1_y_reg;
    logic [COMPONENT_BITS-1:0] s1_z_reg;

    // ------------------------------------------------------------------
    // S2: magnitudes, maxima, special-case flags
    // ------------------------------------------------------------------
    logic [COMPONENT_BITS-1:0]      ax, ay, az, mxy_c, mall_c;
    logic                           s2_valid_reg;
    logic [COMPONENT_BITS-1:0]      s2_x_reg, s2_y_reg, s2_z_reg;
    logic [dtyp_pkg::MAG_W-1:0]     s2_mxy_reg, s2_mxy_next;
    logic [dtyp_pkg::MAG_W-1:0]     s2_mall_reg, s2_mall_next;
    logic                           s2_zero_reg, s2_zero_next;
    logic                           s2_zpos_reg, s2_zpos_next;

    always_comb
    begin
        ax = s1_x_reg[COMPONENT_BITS-1] ? (~s1_x_reg + 1'b1) : s1_x_reg;
        ay = s1_y_reg[COMPONENT_BITS-1] ? (~s1_y_reg + 1'b1) : s1_y_reg;
        az = s1_z_reg[COMPONENT_BITS-1] ? (~s1_z_reg + 1'b1) : s1_z_reg;
        mxy_c  = (ay > ax) ? ay : ax;
        mall_c = (az > mxy_c) ? az : mxy_c;
        s2_mxy_next  = dtyp_pkg::MAG_W'(mxy_c);
        s2_mall_next = dtyp_pkg::MAG_W'(mall_c);
        s2_zero_next = (s1_x_reg == '0) && (s1_y_reg == '0);
        // pitch straight up when z is strictly positive
        s2_zpos_next = !s1_z_reg[COMPONENT_BITS-1] && (s1_z_reg != '0);
    end

    // ------------------------------------------------------------------
    // S3: normalization shifts (yaw pair alone, and all three jointly)
    // ------------------------------------------------------------------
    logic                          s3_valid_reg;
    logic [COMPONENT_BITS-1:0]     s3_x_reg, s3_y_reg, s3_z_reg;
    logic [dtyp_pkg::SHIFT_W-1:0]  s3_k_reg, s3_kj_reg;
    logic                          s3_zero_reg, s3_zpos_reg;

    // ------------------------------------------------------------------
    // S4: apply shifts, pre-rotate the yaw vector by a half turn when x < 0,
    //     form -z at the joint scale
    // ------------------------------------------------------------------
    logic signed [CW-1:0]           xs, ys, zs, nzs;
    dtyp_pkg::cordic_vec_t          s4_vec_next, s4_vec_reg;
    logic [dtyp_pkg::NEGZ_W-1:0]    s4_negz_reg;
    logic [dtyp_pkg::SHIFT_W-1:0]   s4_kd_reg;
    logic                           s4_valid_reg, s4_zero_reg, s4_zpos_reg;

    always_comb
    begin
        xs  = CW'($signed(s3_x_reg)) <<< s3_k_reg;
        ys  = CW'($signed(s3_y_reg)) <<< s3_k_reg;
        zs  = CW'($signed(s3_z_reg)) <<< s3_kj_reg;
        nzs = -zs;
        if (xs[CW-1])
        begin
            s4_vec_next.a   = -xs;
            s4_vec_next.b   = -ys;
            s4_vec_next.ang = dtyp_pkg::HALF_TURN;
        end
        else
        begin
            s4_vec_next.a   = xs;
            s4_vec_next.b   = ys;
            s4_vec_next.ang = '0;
        end
    end

    // ------------------------------------------------------------------
    // S5: vertical term times CORDIC gain (Q30, floored)
    // ------------------------------------------------------------------
    localparam int PROD_W = dtyp_pkg::NEGZ_W + dtyp_pkg::GAIN_W + 1;
    logic signed [PROD_W-1:0] vert_prod;
    logic                     s5_valid_reg;
    dtyp_pkg::cordic_vec_t    s5_vec_reg;
    dtyp_pkg::yaw_side_t      s5_side_reg, s5_side_next;

    always_comb
    begin
        vert_prod = $signed(s4_negz_reg) * $signed({1'b0, dtyp_pkg::GAIN_Q30});
        s5_side_next.vert = CW'(vert_prod >>> 30);
        s5_side_next.kd   = s4_kd_reg;
        s5_side_next.zero = s4_zero_reg;
        s5_side_next.zpos = s4_zpos_reg;
    end

    // ------------------------------------------------------------------
    // Yaw CORDIC pass: NS registered iterations
    // ------------------------------------------------------------------
    logic                     yaw_valid [NS+1];
    dtyp_pkg::cordic_vec_t    yaw_vec   [NS+1];
    logic [YAW_SIDE_W-1:0]    yaw_side  [NS+1];

    assign yaw_valid[0] = s5_valid_reg;
    assign yaw_vec[0]   = s5_vec_reg;
    assign yaw_side[0]  = s5_side_reg;

    for (genvar i = 0; i < NS; i++)
    begin : g_yaw
        dtyp_cordic_stage #(
            .SHIFT  (i),
            .SIDE_W (YAW_SIDE_W)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (yaw_valid[i]),
            .in_vec    (yaw_vec[i]),
            .in_side   (yaw_side[i]),
            .out_valid (yaw_valid[i+1]),
            .out_vec   (yaw_vec[i+1]),
            .out_side  (yaw_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // SH: horizontal length = yaw magnitude scaled down to the joint scale.
    //     The magnitude is never negative, so no pre-rotation is needed.
    // ------------------------------------------------------------------
    dtyp_pkg::yaw_side_t    yaw_out_side;
    logic signed [CW-1:0]   yaw_mag;
    dtyp_pkg::cordic_vec_t  sh_vec_next, sh_vec_reg;
    dtyp_pkg::pitch_side_t  sh_side_next, sh_side_reg;
    logic                   sh_valid_reg;

    always_comb
    begin
        yaw_out_side      = yaw_side[NS];
        yaw_mag           = yaw_vec[NS].a;
        sh_vec_next.a     = yaw_mag >>> yaw_out_side.kd;
        sh_vec_next.b     = yaw_out_side.vert;
        sh_vec_next.ang   = '0;
        sh_side_next.yaw_ang = yaw_vec[NS].ang;
        sh_side_next.zero    = yaw_out_side.zero;
        sh_side_next.zpos    = yaw_out_side.zpos;
    end

    // ------------------------------------------------------------------
    // Pitch CORDIC pass
    // ------------------------------------------------------------------
    logic                     pit_valid [NS+1];
    dtyp_pkg::cordic_vec_t    pit_vec   [NS+1];
    logic [PITCH_SIDE_W-1:0]  pit_side  [NS+1];

    assign pit_valid[0] = sh_valid_reg;
    assign pit_vec[0]   = sh_vec_reg;
    assign pit_side[0]  = sh_side_reg;

    for (genvar i = 0; i < NS; i++)
    begin : g_pitch
        dtyp_cordic_stage #(
            .SHIFT  (i),
            .SIDE_W (PITCH_SIDE_W)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (pit_valid[i]),
            .in_vec    (pit_vec[i]),
            .in_side   (pit_side[i]),
            .out_valid (pit_valid[i+1]),
            .out_vec   (pit_vec[i+1]),
            .out_side  (pit_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // SD1: bam * 360 plus rounding term
    // ------------------------------------------------------------------
    dtyp_pkg::pitch_side_t pit_out_side;
    logic [DW-1:0]         sd1_yaw_next, sd1_pitch_next;
    logic [DW-1:0]         sd1_yaw_reg, sd1_pitch_reg;
    logic                  sd1_valid_reg, sd1_zero_reg, sd1_zpos_reg;

    always_comb
    begin
        pit_out_side   = pit_side[NS];
        sd1_yaw_next   = DW'(pit_out_side.yaw_ang) * DW'(dtyp_pkg::DEG_360) + DEG_RND;
        sd1_pitch_next = DW'(pit_vec[NS].ang) * DW'(dtyp_pkg::DEG_360) + DEG_RND;
    end

    // ------------------------------------------------------------------
    // SD2 (into the output register): scale, wrap a full turn to zero,
    // and substitute the fixed answers for a vertical direction.
    // ------------------------------------------------------------------
    logic [DW-1:0] yaw_deg, pitch_deg;
    logic [AW-1:0] last_yaw, last_pitch;

    always_comb
    begin
        yaw_deg   = sd1_yaw_reg >> DEG_SHR;
        pitch_deg = sd1_pitch_reg >> DEG_SHR;
        if (yaw_deg >= FULL_TURN)
        begin
            yaw_deg = yaw_deg - FULL_TURN;
        end
        if (pitch_deg >= FULL_TURN)
        begin
            pitch_deg = pitch_deg - FULL_TURN;
        end
        if (sd1_zero_reg)
        begin
            yaw_deg   = '0;
            pitch_deg = sd1_zpos_reg ? PITCH_UP : PITCH_DN;
        end
        last_yaw   = yaw_deg[AW-1:0];
        last_pitch = pitch_deg[AW-1:0];
    end

    // ------------------------------------------------------------------
    // Output register plus one-entry skid: the pipeline keeps moving while
    // a finished item waits, and in.ready never depends on out.ready.
    // ------------------------------------------------------------------
    logic          out_valid_reg, out_valid_next;
    logic [AW-1:0] out_yaw_reg, out_yaw_next, out_pitch_reg, out_pitch_next;
    logic [AW-1:0] skid_yaw_reg, skid_yaw_next, skid_pitch_reg, skid_pitch_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_yaw_next    = out_yaw_reg;
        out_pitch_next  = out_pitch_reg;
        skid_valid_next = skid_valid_reg;
        skid_yaw_next   = skid_yaw_reg;
        skid_pitch_next = skid_pitch_reg;
        priority if (skid_valid_reg)
        begin
            if (angles.ready)
            begin
                out_yaw_next    = skid_yaw_reg;
                out_pitch_next  = skid_pitch_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (sd1_valid_reg && (!out_valid_reg || angles.ready))
        begin
            out_valid_next = 1'b1;
            out_yaw_next   = last_yaw;
            out_pitch_next = last_pitch;
        end
        else if (sd1_valid_reg)
        begin
            skid_valid_next = 1'b1;
            skid_yaw_next   = last_yaw;
            skid_pitch_next = last_pitch;
        end
        else if (angles.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            // nothing arrives and nothing leaves: hold
            out_valid_next = out_valid_reg;
        end
    end

    assign angles.valid       = out_valid_reg;
    assign angles.yaw_angle   = out_yaw_reg;
    assign angles.pitch_angle = out_pitch_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            s5_valid_reg   <= 1'b0;
            sh_valid_reg   <= 1'b0;
            sd1_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg  <= dir.valid;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                s4_valid_reg  <= s3_valid_reg;
                s5_valid_reg  <= s4_valid_reg;
                sh_valid_reg  <= yaw_valid[NS];
                sd1_valid_reg <= pit_valid[NS];
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg     <= dir.dir_x;
            s1_y_reg     <= dir.dir_y;
            s1_z_reg     <= dir.dir_z;

            s2_x_reg     <= s1_x_reg;
            s2_y_reg     <= s1_y_reg;
            s2_z_reg     <= s1_z_reg;
            s2_mxy_reg   <= s2_mxy_next;
            s2_mall_reg  <= s2_mall_next;
            s2_zero_reg  <= s2_zero_next;
            s2_zpos_reg  <= s2_zpos_next;

            s3_x_reg     <= s2_x_reg;
            s3_y_reg     <= s2_y_reg;
            s3_z_reg     <= s2_z_reg;
            s3_k_reg     <= norm_shift(s2_mxy_reg);
            s3_kj_reg    <= norm_shift(s2_mall_reg);
            s3_zero_reg  <= s2_zero_reg;
            s3_zpos_reg  <= s2_zpos_reg;

            s4_vec_reg   <= s4_vec_next;
            s4_negz_reg  <= nzs[dtyp_pkg::NEGZ_W-1:0];
            s4_kd_reg    <= s3_k_reg - s3_kj_reg;
            s4_zero_reg  <= s3_zero_reg;
            s4_zpos_reg  <= s3_zpos_reg;

            s5_vec_reg   <= s4_vec_reg;
            s5_side_reg  <= s5_side_next;

            sh_vec_reg   <= sh_vec_next;
            sh_side_reg  <= sh_side_next;

            sd1_yaw_reg   <= sd1_yaw_next;
            sd1_pitch_reg <= sd1_pitch_next;
            sd1_zero_reg  <= pit_out_side.zero;
            sd1_zpos_reg  <= pit_out_side.zpos;
        end
        out_yaw_reg    <= out_yaw_next;
        out_pitch_reg  <= out_pitch_next;
        skid_yaw_reg   <= skid_yaw_next;
        skid_pitch_reg <= skid_pitch_next;
    end

endmodule
